// File: rtl/core/pesd_pkg.sv
// Shared types and constants of the PES packet deframer.
`default_nettype none
package pesd_pkg;

	localparam int unsigned PosW     = 17;
	localparam int unsigned TsW      = 33;
	localparam logic [16:0] PosMax   = 17'h1FFFF;
	localparam logic [7:0]  IdLo     = 8'hC0;
	localparam logic [7:0]  IdHi     = 8'hEF;
	localparam logic [7:0]  StartB   = 8'h01;
	localparam logic [8:0]  FixedHdr = 9'd9;
	localparam logic [8:0]  PtsEnd   = 9'd14;
	localparam logic [8:0]  DtsEnd   = 9'd19;
	localparam logic [16:0] LenHdr   = 17'd6;
	localparam int unsigned DataW    = 88;

	// Byte positions inside the fixed PES header.
	localparam logic [16:0] PosId     = 17'd3;
	localparam logic [16:0] PosLenHi  = 17'd4;
	localparam logic [16:0] PosLenLo  = 17'd5;
	localparam logic [16:0] PosFlags  = 17'd7;
	localparam logic [16:0] PosHdrLen = 17'd8;

	// Result kinds on the output tuser.
	localparam logic KindEs    = 1'b0;
	localparam logic KindFrame = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  es_byte;
		logic [7:0]  stream_number;
		logic        has_presentation;
		logic [32:0] presentation_ticks;
		logic        has_decoding;
		logic [32:0] decoding_ticks;
	} pesd_result_t;

	// Up to two results produced by one input item, in order.
	typedef struct packed {
		logic [1:0]   count;
		pesd_result_t res_a;
		pesd_result_t res_b;
	} pesd_push_t;

endpackage
`default_nettype wire

// File: rtl/core/pes_packet_deframer.sv
// Top level of the PES packet deframer: input register, parser, result queue.
//
//  channel | dir | tdata (low bit up)                                | tuser
//  s_*     | in  | data_byte[7:0]                                    | payload_start
//  m_*     | out | es_byte, stream_number, has_presentation,         | kind
//          |     | presentation_ticks[32:0], has_decoding,           |
//          |     | decoding_ticks[32:0], 4 zero pad bits             |
//
// One byte per cycle is taken while the queue has room; a byte is parsed straight
// out of the input register once the queue has room, and its results enter the queue
// at the next edge.
// A byte yields up to two items (payload byte, frame end); the four-entry
// result queue sets the rate: input stalls while fewer than two entries are free.
// Reset clears the packet state and empties the queue; no pass is needed after it.
`default_nettype none
module pes_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // payload_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // es_byte, stream_number, has_presentation,
	                               // presentation_ticks, has_decoding, decoding_ticks
	output logic        m_tuser    // kind
);
	import pesd_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         us_s1;
	logic         room;
	logic         fire;
	pesd_push_t   push;
	pesd_result_t head;

	// advance the held byte into the parser only when the queue can absorb it
	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			us_s1   <= s_tuser;
		end
	end

	pesd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.data_byte     (byte_s1),
		.payload_start (us_s1),
		.push          (push)
	);

	pesd_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (m_tvalid),
		.head_ready (m_tready),
		.head       (head)
	);

	// pack result fields from the lowest bit up, pad to whole bytes
	assign m_tuser = head.kind;
	assign m_tdata = {4'd0, head.decoding_ticks, head.has_decoding,
		head.presentation_ticks, head.has_presentation, head.stream_number, head.es_byte};

endmodule
`default_nettype wire

// File: rtl/core/pesd_parser.sv
// Packet state and per-byte header parsing of the PES packet deframer.
`default_nettype none
module pesd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              payload_start,
	output pesd_pkg::pesd_push_t push
);
	import pesd_pkg::*;

	logic        in_pkt_q, in_pkt_d;
	logic [16:0] pos_q, pos_d;
	logic [16:0] total_q, total_d;
	logic [7:0]  hel_q, hel_d;
	logic [7:0]  sid_q, sid_d;
	logic [1:0]  tf_q, tf_d;
	logic [32:0] pts_q, pts_d;
	logic [32:0] dts_q, dts_d;
	logic        good_q, good_d;
	logic [7:0]  len_hi_q, len_hi_d;

	function automatic logic [32:0] ts_part(input logic [2:0] k, input logic [7:0] b);
		logic [32:0] v;
		v = '0;
		case (k)
			3'd0: v = {1'b0, b & 8'h0E, 24'd0} << 5;
			3'd1: v = {3'd0, b, 22'd0};
			3'd2: v = {11'd0, b & 8'hFE, 14'd0};
			3'd3: v = {18'd0, b, 7'd0};
			3'd4: v = {26'd0, b[7:1]};
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic frame_ok(input logic good, input logic [16:0] size,
			input logic [7:0] hel);
		logic [8:0] hlen;
		hlen = {1'b0, hel} + FixedHdr;
		return good && (size >= {8'd0, FixedHdr}) && ({8'd0, hlen} <= size);
	endfunction

	function automatic pesd_result_t frame_res(input logic [7:0] sid, input logic [7:0] hel,
			input logic [1:0] tf, input logic [32:0] pts, input logic [32:0] dts);
		pesd_result_t r;
		logic [8:0] hlen;
		logic       pts_ok;
		logic       dts_ok;
		hlen   = {1'b0, hel} + FixedHdr;
		pts_ok = tf[1] && (hlen >= PtsEnd);
		dts_ok = (tf == 2'd3) && (hlen >= DtsEnd);
		r = '0;
		r.kind               = KindFrame;
		r.stream_number      = sid;
		r.has_presentation   = pts_ok;
		r.presentation_ticks = pts_ok ? pts : '0;
		r.has_decoding       = dts_ok;
		r.decoding_ticks     = dts_ok ? dts : '0;
		return r;
	endfunction

	always_comb begin
		pesd_result_t es_r;
		logic [16:0]  p;
		logic [8:0]   hlen;
		logic [15:0]  len;
		logic [1:0]   n;
		in_pkt_d = in_pkt_q;
		pos_d    = pos_q;
		total_d  = total_q;
		hel_d    = hel_q;
		sid_d    = sid_q;
		tf_d     = tf_q;
		pts_d    = pts_q;
		dts_d    = dts_q;
		good_d   = good_q;
		len_hi_d = len_hi_q;
		push     = '0;
		es_r     = '0;
		n        = 2'd0;
		len      = '0;
		hlen     = '0;
		// close a packet still open at a new unit start
		if (payload_start) begin
			if (in_pkt_q && (pos_q != '0) && frame_ok(good_q, pos_q, hel_q)) begin
				push.res_a = frame_res(sid_q, hel_q, tf_q, pts_q, dts_q);
				n = 2'd1;
			end
			pos_d    = '0;
			total_d  = '0;
			hel_d    = '0;
			sid_d    = '0;
			tf_d     = '0;
			pts_d    = '0;
			dts_d    = '0;
			len_hi_d = '0;
			good_d   = 1'b1;
			in_pkt_d = 1'b1;
		end
		p = pos_d;
		if (in_pkt_d) begin
			if (p < PosId) begin
				if (data_byte != ((p == 17'd2) ? StartB : 8'h00)) good_d = 1'b0;
			end else if (p == PosId) begin
				sid_d = data_byte;
				if (data_byte < IdLo || data_byte > IdHi) good_d = 1'b0;
			end else if (p == PosLenHi) begin
				len_hi_d = data_byte;
			end else if (p == PosLenLo) begin
				len = {len_hi_d, data_byte};
				total_d = (len != '0) ? ({1'b0, len} + LenHdr) : '0;
			end else if (p == PosFlags) begin
				tf_d = data_byte[7:6];
			end else if (p == PosHdrLen) begin
				hel_d = data_byte;
			end else if (p != 17'd6) begin
				if (p >= {8'd0, FixedHdr} && p < {8'd0, PtsEnd})
					pts_d = pts_d | ts_part(3'(p - {8'd0, FixedHdr}), data_byte);
				else if (p >= {8'd0, PtsEnd} && p < {8'd0, DtsEnd})
					dts_d = dts_d | ts_part(3'(p - {8'd0, PtsEnd}), data_byte);
				hlen = {1'b0, hel_d} + FixedHdr;
				if (p >= {8'd0, hlen} && good_d) begin
					es_r.kind    = KindEs;
					es_r.es_byte = data_byte;
					if (n == 2'd0) push.res_a = es_r;
					else push.res_b = es_r;
					n = n + 2'd1;
				end
			end
			if (pos_d != PosMax) pos_d = pos_d + 17'd1;
			// close on the byte that completes the declared length
			if (total_d != '0 && pos_d >= total_d) begin
				if (frame_ok(good_d, total_d, hel_d)) begin
					if (n == 2'd0) push.res_a = frame_res(sid_d, hel_d, tf_d, pts_d, dts_d);
					else push.res_b = frame_res(sid_d, hel_d, tf_d, pts_d, dts_d);
					n = n + 2'd1;
				end
				in_pkt_d = 1'b0;
				pos_d    = '0;
				total_d  = '0;
				hel_d    = '0;
				sid_d    = '0;
				tf_d     = '0;
				pts_d    = '0;
				dts_d    = '0;
				good_d   = 1'b0;
				len_hi_d = '0;
			end
		end
		push.count = fire ? n : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
			total_q  <= '0;
			hel_q    <= '0;
			sid_q    <= '0;
			tf_q     <= '0;
			pts_q    <= '0;
			dts_q    <= '0;
			good_q   <= 1'b0;
			len_hi_q <= '0;
		end else if (fire) begin
			in_pkt_q <= in_pkt_d;
			pos_q    <= pos_d;
			total_q  <= total_d;
			hel_q    <= hel_d;
			sid_q    <= sid_d;
			tf_q     <= tf_d;
			pts_q    <= pts_d;
			dts_q    <= dts_d;
			good_q   <= good_d;
			len_hi_q <= len_hi_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/pesd_out_fifo.sv
// Four-entry result queue: takes up to two results a cycle, gives one while the reader is ready.
`default_nettype none
module pesd_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pesd_pkg::pesd_push_t   push,
	output logic                   room,
	output logic                   head_valid,
	input  logic                   head_ready,
	output pesd_pkg::pesd_result_t head
);
	import pesd_pkg::*;

	pesd_result_t mem_q [4];
	logic [1:0]   wp_q;
	logic [1:0]   rp_q;
	logic [2:0]   cnt_q;
	logic         pop;

	assign head_valid = (cnt_q != 3'd0);
	assign head       = mem_q[rp_q];
	assign pop        = head_valid && head_ready;
	// two free entries always guarantee space for the next item
	assign room       = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wp_q] <= push.res_a;
		if (push.count == 2'd2) mem_q[wp_q + 2'd1] <= push.res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push.count;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'd0, pop};
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/pesd_checker.sv
// Port-level checks of the PES packet deframer and their binding.
`default_nettype none
module pesd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic        m_tuser
);
	import pesd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	a_es_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KindEs) |-> (m_tdata[87:8] == '0))
		else $error("payload item carries header fields");

	a_frame_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KindFrame) |->
		(m_tdata[7:0] == '0) && (m_tdata[15:8] >= IdLo) && (m_tdata[15:8] <= IdHi))
		else $error("frame end with bad stream id or payload byte");

	a_ts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KindFrame) |->
		(!m_tdata[50] || m_tdata[16]) && (m_tdata[16] || (m_tdata[49:17] == '0))
		&& (m_tdata[50] || (m_tdata[83:51] == '0)))
		else $error("timestamp flags and values disagree");

endmodule

bind pes_packet_deframer pesd_checker u_pesd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
